// ===== hdl/dtt_pkg.sv =====
// dtt_pkg: shared types and constants for the deadline timer table
// field widths, operation and result codes, controller states, command/status structs
// no dependencies
package dtt_pkg;

  localparam int TIME_W    = 52;
  localparam int PER_W     = 40;
  localparam int SLOT_W    = 4;
  localparam int KIND_W    = 3;
  localparam int OP_W      = 2;
  localparam int MAX_SLOTS = 16;

  // shortest delay the alarm is ever programmed with
  localparam logic [TIME_W-1:0] MIN_DELAY = 52'd100;

  // operation codes; the unused code behaves as a tick
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_NONE      = 3'd5
  } kind_t;

  // which result the datapath builds this cycle
  typedef enum logic [2:0] {
    EMIT_NOTHING = 3'd0,
    EMIT_FULL    = 3'd1,
    EMIT_ADDED   = 3'd2,
    EMIT_CANCEL  = 3'd3,
    EMIT_MID     = 3'd4,
    EMIT_LAST    = 3'd5
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DECODE    = 3'd1,
    ST_ADD_WAIT  = 3'd2,
    ST_ADD_EMIT  = 3'd3,
    ST_TICK_WAIT = 3'd4,
    ST_TICK_EMIT = 3'd5
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load;           // capture the request fields
    logic  scan_start;     // begin a pass over all slots
    logic  tick_init;      // clear taken marks and pending result
    logic  delay_calc;     // register the clamped alarm delay
    logic  delay_from_in;  // delay source: request deadline, else earliest held
    logic  add_commit;     // write the new timer into the free slot
    logic  cancel_commit;  // free the named slot if it is held
    logic  expire_step;    // retire the selected expired slot
    emit_t emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            scan_busy;
    logic            free_found;
    logic            cand_found;
    logic [OP_W-1:0] op;
  } status_t;

endpackage

// ===== hdl/dtt_ctrl.sv =====
// dtt_ctrl: sequencing state machine for the deadline timer table
// drives command struct to dtt_datapath and reads its status; depends on dtt_pkg
module dtt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dtt_pkg::status_t status,
  output dtt_pkg::cmd_t    cmd
);
  import dtt_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NOTHING;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.op)
          OP_ADD: begin
            if (status.free_found) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_ADD_WAIT;
            end else begin
              cmd.emit   = EMIT_FULL;
              state_next = ST_IDLE;
            end
          end
          OP_CANCEL: begin
            cmd.cancel_commit = 1'b1;
            cmd.emit          = EMIT_CANCEL;
            state_next        = ST_IDLE;
          end
          default: begin
            cmd.tick_init  = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = ST_TICK_WAIT;
          end
        endcase
      end
      ST_ADD_WAIT: begin
        if (!status.scan_busy) begin
          cmd.delay_calc    = 1'b1;
          cmd.delay_from_in = 1'b1;
          state_next        = ST_ADD_EMIT;
        end
      end
      ST_ADD_EMIT: begin
        cmd.add_commit = 1'b1;
        cmd.emit       = EMIT_ADDED;
        state_next     = ST_IDLE;
      end
      ST_TICK_WAIT: begin
        // each pass either retires one more expired slot or ends the tick
        if (!status.scan_busy) begin
          if (status.cand_found) begin
            cmd.expire_step = 1'b1;
            cmd.emit        = EMIT_MID;
            cmd.scan_start  = 1'b1;
          end else begin
            cmd.delay_calc = 1'b1;
            state_next     = ST_TICK_EMIT;
          end
        end
      end
      ST_TICK_EMIT: begin
        cmd.emit   = EMIT_LAST;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/dtt_datapath.sv =====
// dtt_datapath: slot storage, scan unit, delay arithmetic and result registers
// controlled by dtt_ctrl through cmd_t/status_t; depends on dtt_pkg
module dtt_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [dtt_pkg::OP_W-1:0]         op,
  input  logic [dtt_pkg::TIME_W-1:0]       deadline_us,
  input  logic [dtt_pkg::PER_W-1:0]        period_us,
  input  logic [dtt_pkg::SLOT_W-1:0]       slot_id,
  input  logic [dtt_pkg::TIME_W-1:0]       now_us,
  input  dtt_pkg::cmd_t                    cmd,
  output dtt_pkg::status_t                 status,
  output logic                             result_valid,
  output logic [dtt_pkg::KIND_W-1:0]       kind,
  output logic [dtt_pkg::SLOT_W-1:0]       slot_id_res,
  output logic                             rearm,
  output logic [dtt_pkg::TIME_W-1:0]       arm_delay_us,
  output logic                             last
);
  import dtt_pkg::*;

  // slot numbers travel in four bits, so at most sixteen slots are used
  localparam int USABLE = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int IW     = $clog2(USABLE);
  localparam logic [IW-1:0]     LAST_IDX = IW'(USABLE - 1);
  localparam logic [SLOT_W:0]   USABLE_L = (SLOT_W + 1)'(USABLE);

  // captured request
  logic [OP_W-1:0]   req_op;
  logic [TIME_W-1:0] req_deadline;
  logic [PER_W-1:0]  req_period;
  logic [SLOT_W-1:0] req_sid;
  logic [TIME_W-1:0] req_now;

  // slot state
  logic [USABLE-1:0] slot_valid;
  logic [USABLE-1:0] taken;
  logic [TIME_W-1:0] deadline_mem [USABLE];
  logic [PER_W-1:0]  period_mem   [USABLE];

  // scan unit
  logic              issuing;
  logic [IW-1:0]     idx;
  logic              rd_vld;
  logic [IW-1:0]     rd_slot;
  logic [TIME_W-1:0] rd_deadline;
  logic [PER_W-1:0]  rd_period;
  logic              rd_valid;
  logic              rd_taken;

  // scan results
  logic              cand_found;
  logic [IW-1:0]     cand_slot;
  logic [TIME_W-1:0] cand_deadline;
  logic [PER_W-1:0]  cand_period;
  logic              earl_found;
  logic [TIME_W-1:0] earl_deadline;

  logic              pending_valid;
  logic [IW-1:0]     pending_slot;
  logic [TIME_W-1:0] delay_q;

  logic              free_found;
  logic [IW-1:0]     free_slot;
  logic              expired_hit;
  logic              earl_hit;
  logic              cancel_hit;
  logic              add_rearm;
  logic [TIME_W:0]   renew_sum;
  logic [TIME_W-1:0] renew_deadline;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_deadline;
  logic [TIME_W-1:0] delay_src;
  logic [TIME_W-1:0] delay_diff;
  logic [TIME_W-1:0] delay_clamped;

  logic              res_fire;
  logic [KIND_W-1:0] res_kind;
  logic [SLOT_W-1:0] res_slot;
  logic              res_rearm;
  logic [TIME_W-1:0] res_delay;
  logic              res_last;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op       <= op;
      req_deadline <= deadline_us;
      req_period   <= period_us;
      req_sid      <= slot_id;
      req_now      <= now_us;
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_slot  = IW'(i);
      end
    end
  end

  assign cancel_hit = ({1'b0, req_sid} < USABLE_L) && slot_valid[req_sid[IW-1:0]];

  // repeat deadline, saturating at the top of the time range
  assign renew_sum      = {1'b0, req_now} + (TIME_W + 1)'(cand_period);
  assign renew_deadline = renew_sum[TIME_W] ? '1 : renew_sum[TIME_W-1:0];

  // single write port shared by add and repeat renewal
  always_comb begin
    wr_en       = cmd.add_commit || (cmd.expire_step && (cand_period != '0));
    wr_addr     = cmd.add_commit ? free_slot : cand_slot;
    wr_deadline = cmd.add_commit ? req_deadline : renew_deadline;
  end

  // deadline and period memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem[wr_addr] <= wr_deadline;
    end
    if (cmd.add_commit) begin
      period_mem[free_slot] <= req_period;
    end
    rd_deadline <= deadline_mem[idx];
    rd_period   <= period_mem[idx];
  end

  // scan address counter, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= issuing;
      if (cmd.scan_start) begin
        issuing <= 1'b1;
        idx     <= '0;
      end else if (issuing) begin
        if (idx == LAST_IDX) begin
          issuing <= 1'b0;
        end
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot  <= idx;
    rd_valid <= slot_valid[idx];
    rd_taken <= taken[idx];
  end

  // compare stage: earliest expired untaken slot, and earliest held slot
  assign expired_hit = rd_valid && !rd_taken && (rd_deadline <= req_now) &&
                       (!cand_found || (rd_deadline < cand_deadline));
  assign earl_hit    = rd_valid && (!earl_found || (rd_deadline < earl_deadline));

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_found <= 1'b0;
      earl_found <= 1'b0;
    end else if (cmd.scan_start) begin
      cand_found <= 1'b0;
      earl_found <= 1'b0;
    end else if (rd_vld) begin
      if (expired_hit) begin
        cand_found <= 1'b1;
      end
      if (earl_hit) begin
        earl_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && expired_hit) begin
      cand_slot     <= rd_slot;
      cand_deadline <= rd_deadline;
      cand_period   <= rd_period;
    end
    if (rd_vld && earl_hit) begin
      earl_deadline <= rd_deadline;
    end
  end

  // valid bits, taken marks and the held-back expired result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      taken         <= '0;
      pending_valid <= 1'b0;
    end else begin
      if (cmd.tick_init) begin
        taken         <= '0;
        pending_valid <= 1'b0;
      end
      if (cmd.add_commit) begin
        slot_valid[free_slot] <= 1'b1;
      end
      if (cmd.cancel_commit && cancel_hit) begin
        slot_valid[req_sid[IW-1:0]] <= 1'b0;
      end
      if (cmd.expire_step) begin
        taken[cand_slot] <= 1'b1;
        pending_valid    <= 1'b1;
        if (cand_period == '0) begin
          slot_valid[cand_slot] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.expire_step) begin
      pending_slot <= cand_slot;
    end
  end

  // clamped alarm delay
  assign delay_src     = cmd.delay_from_in ? req_deadline : earl_deadline;
  assign delay_diff    = delay_src - req_now;
  assign delay_clamped = ((delay_src > req_now) && (delay_diff >= MIN_DELAY)) ?
                         delay_diff : MIN_DELAY;

  always_ff @(posedge clk) begin
    if (cmd.delay_calc) begin
      delay_q <= delay_clamped;
    end
  end

  // new deadline strictly earlier than all held ones, or table was empty
  assign add_rearm = !earl_found || (earl_deadline > req_deadline);

  // result assembly
  always_comb begin
    res_fire  = 1'b0;
    res_kind  = KIND_NONE;
    res_slot  = '0;
    res_rearm = 1'b0;
    res_delay = '0;
    res_last  = 1'b1;
    unique case (cmd.emit)
      EMIT_NOTHING: begin
        res_fire = 1'b0;
      end
      EMIT_FULL: begin
        res_fire = 1'b1;
        res_kind = KIND_FULL;
      end
      EMIT_ADDED: begin
        res_fire  = 1'b1;
        res_kind  = KIND_ADDED;
        res_slot  = SLOT_W'(free_slot);
        res_rearm = add_rearm;
        res_delay = add_rearm ? delay_q : '0;
      end
      EMIT_CANCEL: begin
        res_fire = 1'b1;
        res_kind = cancel_hit ? KIND_CANCELLED : KIND_NOT_FOUND;
        res_slot = req_sid;
      end
      EMIT_MID: begin
        res_fire = pending_valid;
        res_kind = KIND_EXPIRED;
        res_slot = SLOT_W'(pending_slot);
        res_last = 1'b0;
      end
      EMIT_LAST: begin
        res_fire  = 1'b1;
        res_kind  = pending_valid ? KIND_EXPIRED : KIND_NONE;
        res_slot  = pending_valid ? SLOT_W'(pending_slot) : '0;
        res_rearm = earl_found;
        res_delay = earl_found ? delay_q : '0;
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      kind         <= res_kind;
      slot_id_res  <= res_slot;
      rearm        <= res_rearm;
      arm_delay_us <= res_delay;
      last         <= res_last;
    end
  end

  assign status.scan_busy  = issuing | rd_vld;
  assign status.free_found = free_found;
  assign status.cand_found = cand_found;
  assign status.op         = req_op;

endmodule

// ===== hdl/deadline_timer_table_top.sv =====
// deadline_timer_table_top: timer slot table with one-shot alarm re-arm reporting
// instantiates dtt_ctrl and dtt_datapath; depends on dtt_pkg
//
//   channel   handshake                 payload
//   request   start in, busy out        op, deadline_us, period_us, slot_id, now_us
//   result    result_valid out          kind, slot_id_res, rearm, arm_delay_us, last
//
// a request is taken at a rising edge with start high and busy low
// cancel and a full-table add need no scan; an add makes one pass of the scan unit
// a tick makes one pass per expiry and a final pass that finds none: each pass of the
//   scan unit reads one slot per cycle from the deadline memory and retires at most one expiry
// results show for one cycle under result_valid; the receiver cannot stall them
// rst is synchronous: it frees every slot and returns the controller to idle
module deadline_timer_table_top #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtt_pkg::OP_W-1:0]    op,
  input  logic [dtt_pkg::TIME_W-1:0]  deadline_us,
  input  logic [dtt_pkg::PER_W-1:0]   period_us,
  input  logic [dtt_pkg::SLOT_W-1:0]  slot_id,
  input  logic [dtt_pkg::TIME_W-1:0]  now_us,
  output logic                        result_valid,
  output logic [dtt_pkg::KIND_W-1:0]  kind,
  output logic [dtt_pkg::SLOT_W-1:0]  slot_id_res,
  output logic                        rearm,
  output logic [dtt_pkg::TIME_W-1:0]  arm_delay_us,
  output logic                        last
);
  import dtt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  dtt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // storage and arithmetic
  dtt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .deadline_us  (deadline_us),
    .period_us    (period_us),
    .slot_id      (slot_id),
    .now_us       (now_us),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .kind         (kind),
    .slot_id_res  (slot_id_res),
    .rearm        (rearm),
    .arm_delay_us (arm_delay_us),
    .last         (last)
  );

  // a result only ever closes out work that was in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  // the final result of a transaction leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("busy after final result");

  // only expiries can be followed by further results
  a_mid_expired: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> kind == KIND_EXPIRED)
    else $error("non-final result that is not an expiry");

  // a re-arm never asks for less than the minimum delay
  a_rearm_min: assert property (@(posedge clk) disable iff (rst)
    result_valid && rearm |-> arm_delay_us >= MIN_DELAY)
    else $error("alarm delay below minimum");

endmodule

// ===== bench/dtt_checker.sv =====
// dtt_checker: watches the request and result channels of the deadline timer table,
// keeps its own copy of the slot table and compares every result with the prediction
// depends on dtt_pkg
`timescale 1ns / 1ps

module dtt_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [dtt_pkg::OP_W-1:0]   op,
  input  logic [dtt_pkg::TIME_W-1:0] deadline_us,
  input  logic [dtt_pkg::PER_W-1:0]  period_us,
  input  logic [dtt_pkg::SLOT_W-1:0] slot_id,
  input  logic [dtt_pkg::TIME_W-1:0] now_us,
  input  logic                       result_valid,
  input  logic [dtt_pkg::KIND_W-1:0] kind,
  input  logic [dtt_pkg::SLOT_W-1:0] slot_id_res,
  input  logic                       rearm,
  input  logic [dtt_pkg::TIME_W-1:0] arm_delay_us,
  input  logic                       last,
  output int                         errors,
  output int                         pending
);
  import dtt_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic              rearm;
    logic [TIME_W-1:0] delay;
    logic              last;
  } timer_result_t;

  // shadow copy of the slot table
  logic              held     [MAX_SLOTS];
  logic [TIME_W-1:0] due_time [MAX_SLOTS];
  logic [PER_W-1:0]  repeat_by[MAX_SLOTS];

  timer_result_t pending_results[$];
  int            err_count;

  function automatic logic [TIME_W-1:0] alarm_delay(logic [TIME_W-1:0] due,
                                                    logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = (due > now) ? due - now : '0;
    return (d < MIN_DELAY) ? MIN_DELAY : d;
  endfunction

  // lowest slot among those holding the earliest deadline, -1 if none held
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (held[i] && (best < 0 || due_time[i] < due_time[best])) best = i;
    end
    return best;
  endfunction

  function automatic void push_result(kind_t k, int s, logic r, logic [TIME_W-1:0] d,
                                      logic l);
    timer_result_t res;
    res.kind  = k;
    res.slot  = SLOT_W'(s);
    res.rearm = r;
    res.delay = d;
    res.last  = l;
    pending_results.insert(pending_results.size(), res);
  endfunction

  // apply one accepted request to the shadow table and queue its results
  function automatic void apply_timer_op(logic [OP_W-1:0] code, logic [TIME_W-1:0] due,
                                         logic [PER_W-1:0] per, logic [SLOT_W-1:0] sid,
                                         logic [TIME_W-1:0] now);
    int                free_slot;
    int                first;
    int                best;
    int                n;
    int                order[MAX_SLOTS];
    logic              taken[MAX_SLOTS];
    logic [TIME_W:0]   sum;
    logic              do_rearm;
    logic [TIME_W-1:0] delay;
    free_slot = -1;
    n = 0;
    do_rearm = 1'b0;
    delay = '0;
    case (code)
      OP_ADD: begin
        for (int i = MAX_SLOTS - 1; i >= 0; i--) if (!held[i]) free_slot = i;
        if (free_slot < 0) begin
          push_result(KIND_FULL, 0, 1'b0, '0, 1'b1);
        end else begin
          first = earliest_slot();
          held[free_slot]      = 1'b1;
          due_time[free_slot]  = due;
          repeat_by[free_slot] = per;
          if (first < 0 || due_time[first] > due)
            push_result(KIND_ADDED, free_slot, 1'b1, alarm_delay(due, now), 1'b1);
          else
            push_result(KIND_ADDED, free_slot, 1'b0, '0, 1'b1);
        end
      end
      OP_CANCEL: begin
        if (held[sid]) begin
          held[sid] = 1'b0;
          push_result(KIND_CANCELLED, int'(sid), 1'b0, '0, 1'b1);
        end else begin
          push_result(KIND_NOT_FOUND, int'(sid), 1'b0, '0, 1'b1);
        end
      end
      default: begin
        // tick: collect due slots in deadline order, lower slot wins ties
        for (int i = 0; i < MAX_SLOTS; i++) taken[i] = 1'b0;
        forever begin
          best = -1;
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (held[i] && !taken[i] && due_time[i] <= now &&
                (best < 0 || due_time[i] < due_time[best])) best = i;
          end
          if (best < 0) break;
          taken[best] = 1'b1;
          order[n] = best;
          n++;
        end
        // repeating slots move to now plus period, saturating; one-shots are freed
        for (int k = 0; k < n; k++) begin
          if (repeat_by[order[k]] != '0) begin
            sum = {1'b0, now} + (TIME_W + 1)'(repeat_by[order[k]]);
            due_time[order[k]] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          end else begin
            held[order[k]] = 1'b0;
          end
        end
        first = earliest_slot();
        if (first >= 0) begin
          do_rearm = 1'b1;
          delay = alarm_delay(due_time[first], now);
        end
        if (n == 0) begin
          push_result(KIND_NONE, 0, do_rearm, delay, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            if (k == n - 1) push_result(KIND_EXPIRED, order[k], do_rearm, delay, 1'b1);
            else            push_result(KIND_EXPIRED, order[k], 1'b0, '0, 1'b0);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string fname, logic [TIME_W-1:0] exp_val,
                                      logic [TIME_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", fname, exp_val, act_val);
      err_count++;
    end
  endfunction

  // results first, so a result and a new request at one edge keep their order
  always @(posedge clk) begin
    timer_result_t exp_res;
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        held[i] = 1'b0;
        due_time[i] = '0;
        repeat_by[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d slot %0d", kind, slot_id_res);
          err_count++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("kind", TIME_W'(exp_res.kind), TIME_W'(kind));
          check_field("slot_id_res", TIME_W'(exp_res.slot), TIME_W'(slot_id_res));
          check_field("rearm", TIME_W'(exp_res.rearm), TIME_W'(rearm));
          check_field("arm_delay_us", exp_res.delay, arm_delay_us);
          check_field("last", TIME_W'(exp_res.last), TIME_W'(last));
        end
      end
      if (start && !busy)
        apply_timer_op(op, deadline_us, period_us, slot_id, now_us);
    end
    errors  <= err_count;
    pending <= pending_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus and verdict for deadline_timer_table_top
// drives directed and random timer requests in bursts; checking lives in dtt_checker
// depends on dtt_pkg, deadline_timer_table_top and dtt_checker
`timescale 1ns / 1ps

module tb_top;
  import dtt_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
  localparam logic [PER_W-1:0]  PERIOD_MAX    = {PER_W{1'b1}};
  // the spare operation code is handled as a tick
  localparam logic [OP_W-1:0]   OP_TICK_ALIAS = 2'd3;
  localparam int                RANDOM_ITEMS  = 360;
  localparam int                DRAIN_CYCLES  = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   op = '0;
  logic [TIME_W-1:0] deadline_us = '0;
  logic [PER_W-1:0]  period_us = '0;
  logic [SLOT_W-1:0] slot_id = '0;
  logic [TIME_W-1:0] now_us = '0;
  logic              result_valid;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot_id_res;
  logic              rearm;
  logic [TIME_W-1:0] arm_delay_us;
  logic              last;
  int                errors;
  int                pending;

  deadline_timer_table_top u_top (
    .clk, .rst, .start, .busy, .op, .deadline_us, .period_us, .slot_id, .now_us,
    .result_valid, .kind, .slot_id_res, .rearm, .arm_delay_us, .last
  );

  dtt_checker u_checker (
    .clk, .rst, .start, .busy, .op, .deadline_us, .period_us, .slot_id, .now_us,
    .result_valid, .kind, .slot_id_res, .rearm, .arm_delay_us, .last,
    .errors, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // present one request and hold it until the block takes it; start stays high
  task automatic send_request(logic [OP_W-1:0] code, logic [TIME_W-1:0] due,
                              logic [PER_W-1:0] per, logic [SLOT_W-1:0] sid,
                              logic [TIME_W-1:0] now);
    start       <= 1'b1;
    op          <= code;
    deadline_us <= due;
    period_us   <= per;
    slot_id     <= sid;
    now_us      <= now;
    do @(posedge clk); while (busy);
  endtask

  // lower start and wait until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] tnow;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] last_due;
    logic [PER_W-1:0]  per;
    logic [OP_W-1:0]   code;
    int                pick;
    int                burst_left;
    int                gap;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, ties, clamping, full table, saturation
    send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_CANCEL, '0, '0, 4'd3, '0);
    send_request(OP_ADD, TIME_MAX, PERIOD_MAX, '0, '0);
    send_request(OP_ADD, 52'd1000, '0, '0, '0);
    send_request(OP_ADD, 52'd1000, '0, '0, '0);
    send_request(OP_ADD, 52'd40, 40'd250, '0, '0);
    send_request(OP_ADD, 52'd5, '0, '0, 52'd10);
    for (int i = 0; i < 10; i++)
      send_request(OP_ADD, 52'(200 + 50 * i), '0, '0, 52'd10);
    send_request(OP_ADD, 52'd1000, PERIOD_MAX, '0, 52'd10);
    send_request(OP_ADD, 52'd1, '0, '0, 52'd10);
    send_request(OP_CANCEL, '0, '0, 4'd2, 52'd10);
    send_request(OP_TICK_ALIAS, '0, '0, '0, 52'd1000);
    send_request(OP_TICK, '0, '0, '0, TIME_MAX - 52'd5);
    send_request(OP_TICK, '0, '0, '0, TIME_MAX);
    send_request(OP_CANCEL, '0, '0, 4'd15, TIME_MAX);
    wait_drained();

    // random: timers added near the running clock, ticks advancing it
    tnow = 52'd5000;
    last_due = tnow;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      if (n == RANDOM_ITEMS / 2) wait_drained();

      // advance the clock, now and then jump anywhere
      if ($urandom_range(0, 99) < 8) tnow = rand_time();
      else tnow = tnow + 52'($urandom_range(0, 400));

      pick = $urandom_range(0, 99);
      if (pick < 60)      due = tnow + 52'($urandom_range(0, 1500));
      else if (pick < 75) due = tnow - 52'($urandom_range(0, 300));
      else if (pick < 85) due = last_due;
      else if (pick < 95) due = rand_time();
      else                due = TIME_MAX;

      pick = $urandom_range(0, 99);
      if (pick < 45)      per = '0;
      else if (pick < 80) per = 40'($urandom_range(1, 600));
      else if (pick < 95) per = PER_W'({$urandom, $urandom});
      else                per = PERIOD_MAX;

      pick = $urandom_range(0, 99);
      if (pick < 40)      code = OP_ADD;
      else if (pick < 60) code = OP_CANCEL;
      else if (pick < 95) code = OP_TICK;
      else                code = OP_TICK_ALIAS;

      if (code == OP_ADD) begin
        last_due = due;
        send_request(code, due, per, 4'($urandom_range(0, 15)), tnow);
      end else begin
        // fields the operation ignores carry noise
        send_request(code, rand_time(), PER_W'({$urandom, $urandom}),
                     4'($urandom_range(0, 15)), tnow);
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
